### rtl/core/assert_macros.svh
// assertion macros shared by the pulse meter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication check
`define PM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// next-cycle implication check
`define PM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

### rtl/core/pm_pkg.sv
// types, constants and helpers of the pulse meter
`timescale 1ns / 1ps

package pm_pkg;

   // default configuration
   localparam int TARIFF_COUNT_DEF = 4;
   localparam int SLOT_COUNT_DEF   = 4;

   // field widths
   localparam int COUNT_W     = 16;
   localparam int TARIFF_W    = 8;
   localparam int TAR_W       = 3;
   localparam int ENERGY_W    = 27;
   localparam int POWER_W     = 28;
   localparam int CONST_W     = 16;
   localparam int DIR_W       = 2;
   localparam int SUM_W       = 18;
   localparam int SCALE_W     = 20;
   localparam int DIV_W       = 38;
   localparam int PULSE_DIV_W = 30;
   localparam int ITER_W      = 6;
   localparam int STEP_W      = 3;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;

   // arithmetic constants
   localparam logic [ENERGY_W-1:0] ENERGY_MOD  = 27'd100000000;
   localparam logic [ENERGY_W-1:0] POWER_LIMIT = 27'd80000000;
   localparam logic [SCALE_W-1:0]  PULSE_SCALE = 20'd10000;
   localparam logic [SCALE_W-1:0]  TICK_SCALE  = 20'd600000;

   // request action codes
   localparam logic ACT_PULSE = 1'b0;
   localparam logic ACT_TICK  = 1'b1;

   // register index codes
   localparam logic REG_METER_CONSTANT = 1'b0;
   localparam logic REG_DIRECTION      = 1'b1;

   // first reverse direction code
   localparam logic [DIR_W-1:0] DIR_REVERSE_MIN = 2'd2;

   typedef struct packed {
      logic                action;
      logic [COUNT_W-1:0]  pulse_count;
      logic [TARIFF_W-1:0] tariff;
   } pm_req_type;

   typedef struct packed {
      logic signed [POWER_W-1:0] power;
      logic [ENERGY_W-1:0]       lifetime_total;
      logic [ENERGY_W-1:0]       day_total;
      logic [ENERGY_W-1:0]       month_total;
      logic [TAR_W-1:0]          tariff_used;
      logic [ENERGY_W-1:0]       lifetime_tariff;
      logic [ENERGY_W-1:0]       day_tariff;
      logic [ENERGY_W-1:0]       month_tariff;
   } pm_rsp_type;

   typedef struct packed {
      logic [CONST_W-1:0] meter_constant;
      logic [DIR_W-1:0]   direction_code;
   } pm_cfg_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [ITER_W-1:0] iters;
   } pm_div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } pm_div_stat_type;

   // binary-weighted multiples of the energy modulus for the quotient reduction
   function automatic logic [PULSE_DIV_W-1:0] mod_step_value(input logic [1:0] idx);
      logic [PULSE_DIV_W-1:0] val;
      case (idx)
         2'd0:    val = 30'd800000000;
         2'd1:    val = 30'd400000000;
         2'd2:    val = 30'd200000000;
         default: val = 30'd100000000;
      endcase
      return val;
   endfunction

endpackage

### rtl/core/pm_csr.sv
// configuration register file with apb-style access
`timescale 1ns / 1ps

module pm_csr
   import pm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output pm_cfg_type        cfg
);

   logic [CONST_W-1:0] const_ff, const_in;
   logic [DIR_W-1:0]   dir_ff, dir_in;
   logic               reg_idx;
   logic               wr_en;

   // register index from the word address
   assign reg_idx = paddr[CSR_AW-1];
   assign wr_en   = psel && penable && pwrite;

   // write decode
   always_comb begin
      const_in = const_ff;
      dir_in   = dir_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_METER_CONSTANT: const_in = pwdata[CONST_W-1:0];
            REG_DIRECTION:      dir_in   = pwdata[DIR_W-1:0];
            default:            ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         const_ff <= '0;
         dir_ff   <= '0;
      end else begin
         const_ff <= const_in;
         dir_ff   <= dir_in;
      end
   end

   // read decode
   always_comb begin
      unique case (reg_idx)
         REG_METER_CONSTANT: prdata = CSR_DW'(const_ff);
         REG_DIRECTION:      prdata = CSR_DW'(dir_ff);
         default:            prdata = '0;
      endcase
   end

   assign cfg.meter_constant = const_ff;
   assign cfg.direction_code = dir_ff;

endmodule

### rtl/core/pm_div.sv
// serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pm_div
   import pm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  pm_div_cmd_type     cmd,
   input  logic [CONST_W-1:0] divisor,
   output pm_div_stat_type    stat,
   output logic [DIV_W-1:0]   quotient,
   output logic [CONST_W-1:0] remainder
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [ITER_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_W-1:0]   dvd_ff, dvd_in;
   logic [DIV_W-1:0]   quo_ff, quo_in;
   logic [CONST_W-1:0] rem_ff, rem_in;
   logic [CONST_W-1:0] dsr_ff, dsr_in;
   logic [CONST_W:0]   trial;
   logic [CONST_W:0]   diff;
   logic               fits;

   // trial subtract of the shifted partial remainder
   assign trial = {rem_ff, dvd_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = (trial >= {1'b0, dsr_ff});

   // step control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = cmd.iters;
         dvd_in  = cmd.dividend;
         quo_in  = '0;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[CONST_W-1:0] : trial[CONST_W-1:0];
         dvd_in = {dvd_ff[DIV_W-2:0], 1'b0};
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - ITER_W'(1);
         if (cnt_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   // checks
   `PM_ASSERT_IMPL(a_no_restart, clock, reset, cmd.start, !busy_ff && !done_ff)
   `PM_ASSERT_NEXT(a_done_single, clock, reset, done_ff, !done_ff)
   `PM_ASSERT_IMPL(a_rem_below_divisor, clock, reset, busy_ff, rem_ff < dsr_ff)

endmodule

### rtl/core/pm_energy.sv
// energy register file with modulo credit adder
`timescale 1ns / 1ps

module pm_energy
   import pm_pkg::*;
#(
   parameter int TARIFF_COUNT = TARIFF_COUNT_DEF
)(
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    wr_en,
   input  logic [$clog2(3*(TARIFF_COUNT+1))-1:0]   addr,
   input  logic [ENERGY_W-1:0]                     add_val,
   output logic [ENERGY_W-1:0]                     new_val
);

   localparam int STORE_LEN = 3 * (TARIFF_COUNT + 1);

   logic [ENERGY_W-1:0] store_ff [STORE_LEN];
   logic [ENERGY_W:0]   sum;

   // add and wrap at the energy modulus
   always_comb begin
      sum = {1'b0, store_ff[addr]} + {1'b0, add_val};
      if (sum >= {1'b0, ENERGY_MOD}) begin
         sum = sum - {1'b0, ENERGY_MOD};
      end
      new_val = sum[ENERGY_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STORE_LEN; i++) begin
            store_ff[i] <= '0;
         end
      end else if (wr_en) begin
         store_ff[addr] <= new_val;
      end
   end

endmodule

### rtl/core/pulse_input_energy_power_meter_top.sv
// pulse meter channel: sequencer, demand slots, shared divider and result register
// pulse batches with crediting and demand ticks run through the serial divider at one
// quotient bit per cycle; other requests skip it. one request at a time, taken the cycle
// after the result is loaded. energy store updates one entry per cycle.
// synchronous active-high reset clears totals, remainder, demand slots and registers.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pulse_input_energy_power_meter_top
   import pm_pkg::*;
#(
   parameter int TARIFF_COUNT = TARIFF_COUNT_DEF,
   parameter int SLOT_COUNT   = SLOT_COUNT_DEF
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pm_req_type        req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pm_rsp_type        rsp_payload,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int GROUP_LEN = TARIFF_COUNT + 1;
   localparam int AW        = $clog2(3 * GROUP_LEN);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_MOD   = 3'd3;
   localparam logic [2:0] ST_SWEEP = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   // sweep steps over the energy store
   localparam logic [STEP_W-1:0] SW_LIFE_TOTAL  = 3'd0;
   localparam logic [STEP_W-1:0] SW_LIFE_TARIFF = 3'd1;
   localparam logic [STEP_W-1:0] SW_DAY_TOTAL   = 3'd2;
   localparam logic [STEP_W-1:0] SW_DAY_TARIFF  = 3'd3;
   localparam logic [STEP_W-1:0] SW_MONTH_TOTAL = 3'd4;
   localparam logic [STEP_W-1:0] SW_MONTH_TARIFF = 3'd5;

   // energy groups
   localparam logic [1:0] GRP_LIFE  = 2'd0;
   localparam logic [1:0] GRP_DAY   = 2'd1;

   localparam logic [1:0] MOD_LAST = 2'd3;

   pm_cfg_type          csr_cfg;
   pm_div_cmd_type      div_cmd;
   pm_div_stat_type     div_stat;
   logic [DIV_W-1:0]    div_quo;
   logic [CONST_W-1:0]  div_rem;

   logic [2:0]             state_ff, state_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   act_ff, act_in;
   logic                   credit_ff, credit_in;
   logic [TAR_W-1:0]       tar_ff, tar_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [CONST_W-1:0]     dr_ff, dr_in;
   logic [PULSE_DIV_W-1:0] qm_ff, qm_in;
   logic [POWER_W-1:0]     power_ff, power_in;
   pm_rsp_type             stage_ff, stage_in;
   pm_rsp_type             rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]     slot_ff [SLOT_COUNT];
   logic [COUNT_W-1:0]     slot_in [SLOT_COUNT];

   logic                   req_accept;
   logic [TAR_W-1:0]       tar_map;
   logic [SUM_W-1:0]       slot_sum;
   logic [SUM_W-1:0]       mul_a;
   logic [SCALE_W-1:0]     mul_b;
   logic [DIV_W-1:0]       prod;
   logic [PULSE_DIV_W-1:0] pulse_num;
   logic [POWER_W-1:0]     power_mag;
   logic [PULSE_DIV_W-1:0] mod_val;
   logic [AW-1:0]          grp_base;
   logic [AW-1:0]          en_addr;
   logic                   en_wr;
   logic [ENERGY_W-1:0]    en_new;
   logic                   out_free;

   // configuration registers
   pm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (csr_cfg)
   );
   assign csr_pready = 1'b1;

   // shared serial divider
   pm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .cmd       (div_cmd),
      .divisor   (csr_cfg.meter_constant),
      .stat      (div_stat),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // energy totals
   pm_energy #(
      .TARIFF_COUNT (TARIFF_COUNT)
   ) u_energy (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (en_wr),
      .addr    (en_addr),
      .add_val (qm_ff[ENERGY_W-1:0]),
      .new_val (en_new)
   );

   // request handshake and tariff mapping
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign tar_map    = (req_payload.tariff == '0 ||
                        req_payload.tariff > TARIFF_W'(TARIFF_COUNT)) ?
                       TAR_W'(TARIFF_COUNT) : req_payload.tariff[TAR_W-1:0];

   // demand over the four newest slots
   assign slot_sum = SUM_W'(slot_ff[0]) + SUM_W'(slot_ff[1]) +
                     SUM_W'(slot_ff[2]) + SUM_W'(slot_ff[3]);

   // scaling multiply ahead of the divider
   assign mul_a     = (act_ff == ACT_TICK) ? sum_ff : SUM_W'(count_ff);
   assign mul_b     = (act_ff == ACT_TICK) ? TICK_SCALE : PULSE_SCALE;
   assign prod      = {{(DIV_W-SUM_W){1'b0}}, mul_a} * {{(DIV_W-SCALE_W){1'b0}}, mul_b};
   assign pulse_num = prod[PULSE_DIV_W-1:0] + PULSE_DIV_W'(dr_ff);

   assign div_cmd.start    = (state_ff == ST_MUL);
   assign div_cmd.dividend = (act_ff == ACT_TICK) ? prod :
                             {pulse_num, {(DIV_W-PULSE_DIV_W){1'b0}}};
   assign div_cmd.iters    = (act_ff == ACT_TICK) ? ITER_W'(DIV_W) : ITER_W'(PULSE_DIV_W);

   // power clamp
   assign power_mag = (div_quo >= DIV_W'(POWER_LIMIT)) ? '0 : div_quo[POWER_W-1:0];

   assign mod_val = mod_step_value(step_ff[1:0]);

   // energy address for the current sweep step
   always_comb begin
      case (step_ff[STEP_W-1:1])
         GRP_LIFE: grp_base = '0;
         GRP_DAY:  grp_base = AW'(GROUP_LEN);
         default:  grp_base = AW'(2 * GROUP_LEN);
      endcase
      en_addr = grp_base + (step_ff[0] ? AW'(tar_ff) : '0);
   end
   assign en_wr = credit_ff && (state_ff == ST_SWEEP);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      act_in       = act_ff;
      credit_in    = credit_ff;
      tar_in       = tar_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      dr_in        = dr_ff;
      qm_in        = qm_ff;
      power_in     = power_ff;
      stage_in     = stage_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               act_in    = req_payload.action;
               count_in  = req_payload.pulse_count;
               tar_in    = tar_map;
               sum_in    = slot_sum;
               qm_in     = '0;
               power_in  = '0;
               step_in   = '0;
               credit_in = (req_payload.action == ACT_PULSE) &&
                           (req_payload.pulse_count != '0) &&
                           (csr_cfg.meter_constant != '0);
               if (csr_cfg.meter_constant != '0 &&
                   (req_payload.action == ACT_TICK || req_payload.pulse_count != '0)) begin
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_SWEEP;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               step_in = '0;
               if (act_ff == ACT_TICK) begin
                  power_in = (csr_cfg.direction_code >= DIR_REVERSE_MIN) ?
                             (POWER_W'(0) - power_mag) : power_mag;
                  state_in = ST_SWEEP;
               end else begin
                  dr_in    = div_rem;
                  qm_in    = div_quo[PULSE_DIV_W-1:0];
                  state_in = ST_MOD;
               end
            end
         end
         ST_MOD: begin
            if (qm_ff >= mod_val) begin
               qm_in = qm_ff - mod_val;
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff[1:0] == MOD_LAST) begin
               step_in  = '0;
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            case (step_ff)
               SW_LIFE_TOTAL:  stage_in.lifetime_total  = en_new;
               SW_LIFE_TARIFF: stage_in.lifetime_tariff = en_new;
               SW_DAY_TOTAL:   stage_in.day_total       = en_new;
               SW_DAY_TARIFF:  stage_in.day_tariff      = en_new;
               SW_MONTH_TOTAL: stage_in.month_total     = en_new;
               default:        stage_in.month_tariff    = en_new;
            endcase
            step_in = step_ff + STEP_W'(1);
            if (step_ff == SW_MONTH_TARIFF) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_in             = stage_ff;
               rsp_in.power       = power_ff;
               rsp_in.tariff_used = tar_ff;
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // demand slot update at request accept
   always_comb begin
      for (int k = 0; k < SLOT_COUNT; k++) begin
         slot_in[k] = slot_ff[k];
      end
      if (req_accept) begin
         if (req_payload.action == ACT_TICK) begin
            for (int k = 1; k < SLOT_COUNT; k++) begin
               slot_in[k] = slot_ff[k-1];
            end
            slot_in[0] = '0;
         end else begin
            slot_in[0] = slot_ff[0] + req_payload.pulse_count;
         end
      end
   end

   // control and model state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         dr_ff        <= '0;
         for (int k = 0; k < SLOT_COUNT; k++) begin
            slot_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         dr_ff        <= dr_in;
         for (int k = 0; k < SLOT_COUNT; k++) begin
            slot_ff[k] <= slot_in[k];
         end
      end
   end

   // request payload and result registers
   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      credit_ff <= credit_in;
      tar_ff    <= tar_in;
      count_ff  <= count_in;
      sum_ff    <= sum_in;
      qm_ff     <= qm_in;
      power_ff  <= power_in;
      stage_ff  <= stage_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // checks
   `PM_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && !req_stall, state_ff != ST_IDLE)
   `PM_ASSERT_IMPL(a_rsp_tariff_range, clock, reset, rsp_valid_ff, rsp_ff.tariff_used != '0 && rsp_ff.tariff_used <= TAR_W'(TARIFF_COUNT))
   `PM_ASSERT_IMPL(a_rem_below_const, clock, reset, state_ff == ST_MOD, dr_ff < csr_cfg.meter_constant)

endmodule

### sim/testbench.sv
// self-checking testbench for the pulse meter channel: predictor, random traffic, csr phases
`timescale 1ns / 1ps

module testbench;
   import pm_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 60;
   localparam int ITEMS_PER_SET = 240;
   localparam int RANDOM_SETS   = 8;
   localparam int GROUP_LEN     = TARIFF_COUNT_DEF + 1;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   pm_req_type        req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   pm_rsp_type        rsp_payload;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   // queues between stimulus, driver and monitor
   pm_req_type pending_requests[$];
   pm_rsp_type expected_readings[$];

   // shadow meter state
   logic [ENERGY_W-1:0] energy_regs[3*GROUP_LEN];
   logic [CONST_W-1:0]  carry_rem;
   logic [COUNT_W-1:0]  demand_hist[4];
   logic [CONST_W-1:0]  meter_k;
   logic [DIR_W-1:0]    dir_code;

   int cycle_count = 0;
   int fail_count  = 0;
   int hold_left   = 0;

   pulse_input_energy_power_meter_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // cycle count and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** pulse_input_energy_power_meter_top: FAILED **");
         $finish;
      end
   end

   // add an energy quotient to one register, wrapping at the energy modulus
   function automatic logic [ENERGY_W-1:0] wrap_add(input logic [ENERGY_W-1:0] acc,
                                                     input longint unsigned q);
      longint unsigned v;
      v = 64'(acc) + q;
      return ENERGY_W'(v % 64'(ENERGY_MOD));
   endfunction

   // meter behavior for one request, updates the shadow state
   function automatic pm_rsp_type meter_advance(input pm_req_type r);
      pm_rsp_type      o;
      int unsigned     t;
      longint unsigned num, q, sum, p;
      t = (r.tariff == 0 || r.tariff > TARIFF_COUNT_DEF) ? TARIFF_COUNT_DEF : r.tariff;
      p = 0;
      if (r.action == ACT_PULSE) begin
         // pulse batch: demand slot, then energy crediting when the constant is set
         if (r.pulse_count != 0) begin
            demand_hist[0] = demand_hist[0] + r.pulse_count;
            if (meter_k != 0) begin
               num = 64'(r.pulse_count) * 64'(PULSE_SCALE) + 64'(carry_rem);
               q = num / 64'(meter_k);
               carry_rem = CONST_W'(num % 64'(meter_k));
               for (int g = 0; g < 3; g++) begin
                  energy_regs[g*GROUP_LEN]     = wrap_add(energy_regs[g*GROUP_LEN], q);
                  energy_regs[g*GROUP_LEN + t] = wrap_add(energy_regs[g*GROUP_LEN + t], q);
               end
            end
         end
      end else begin
         // demand tick: power from the four newest slots, then shift
         if (meter_k != 0) begin
            sum = 0;
            for (int k = 0; k < 4; k++) sum += 64'(demand_hist[k]);
            p = sum * 64'(TICK_SCALE) / 64'(meter_k);
            if (p >= 64'(POWER_LIMIT)) p = 0;
            if (dir_code >= DIR_REVERSE_MIN) p = 64'd0 - p;
         end
         for (int k = 3; k > 0; k--) demand_hist[k] = demand_hist[k-1];
         demand_hist[0] = '0;
      end
      o.power           = p[POWER_W-1:0];
      o.lifetime_total  = energy_regs[0];
      o.day_total       = energy_regs[GROUP_LEN];
      o.month_total     = energy_regs[2*GROUP_LEN];
      o.tariff_used     = TAR_W'(t);
      o.lifetime_tariff = energy_regs[t];
      o.day_tariff      = energy_regs[GROUP_LEN + t];
      o.month_tariff    = energy_regs[2*GROUP_LEN + t];
      return o;
   endfunction

   function automatic pm_req_type make_request(input logic act, input int unsigned count,
                                               input int unsigned tar);
      pm_req_type r;
      r.action      = act;
      r.pulse_count = COUNT_W'(count);
      r.tariff      = TARIFF_W'(tar);
      return r;
   endfunction

   // random request: mostly pulses, counts spread over small, large and full range
   function automatic pm_req_type random_request();
      int unsigned count, tar;
      logic        act;
      case ($urandom_range(9))
         0:       count = 0;
         1, 2, 3: count = $urandom_range(1, 200);
         4, 5, 6: count = $urandom_range(65535);
         7, 8:    count = $urandom_range(60000, 65535);
         default: count = 1 << $urandom_range(15);
      endcase
      tar = ($urandom_range(9) < 7) ? $urandom_range(5) : $urandom_range(255);
      act = ($urandom_range(3) == 0) ? ACT_TICK : ACT_PULSE;
      return make_request(act, count, tar);
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_readings.push_back(meter_advance(req_payload));
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() != 0 &&
                ((cycle_count % 5000) < 1500 || $urandom_range(99) >= 30)) begin
               req_valid   <= 1'b1;
               req_payload <= pending_requests.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               $error("result with no request outstanding");
               fail_count++;
            end else begin
               pm_rsp_type want;
               want = expected_readings.pop_front();
               check_field("power", want.power, rsp_payload.power);
               check_field("lifetime_total", want.lifetime_total, rsp_payload.lifetime_total);
               check_field("day_total", want.day_total, rsp_payload.day_total);
               check_field("month_total", want.month_total, rsp_payload.month_total);
               check_field("tariff_used", want.tariff_used, rsp_payload.tariff_used);
               check_field("lifetime_tariff", want.lifetime_tariff,
                           rsp_payload.lifetime_tariff);
               check_field("day_tariff", want.day_tariff, rsp_payload.day_tariff);
               check_field("month_tariff", want.month_tariff, rsp_payload.month_tariff);
            end
         end
         // long hold-off twice during the random traffic
         if (cycle_count == 15000 || cycle_count == 50000) begin
            hold_left <= 400;
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (cycle_count % 5000) >= 1500 && $urandom_range(99) < 30;
         end
      end
   end

   // apb write: setup cycle, then access cycle until pready
   task automatic write_register(input logic [CSR_AW-1:0] addr, input logic [CSR_DW-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // both registers, with junk in the unused upper bits
   task automatic set_meter(input logic [CONST_W-1:0] k, input logic [DIR_W-1:0] dir);
      write_register({REG_METER_CONSTANT, 2'b00}, {16'($urandom), k});
      meter_k = k;
      write_register({REG_DIRECTION, 2'b00}, {30'($urandom), dir});
      dir_code = dir;
   endtask

   task automatic drain();
      while (pending_requests.size() != 0 || req_valid || expected_readings.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // stimulus
   initial begin
      logic [CONST_W-1:0] k;
      for (int i = 0; i < 3*GROUP_LEN; i++) energy_regs[i] = '0;
      for (int i = 0; i < 4; i++) demand_hist[i] = '0;
      carry_rem = '0;
      meter_k   = '0;
      dir_code  = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset configuration: zero constant, slots still fill and shift
      pending_requests.push_back(make_request(ACT_PULSE, 500, 1));
      pending_requests.push_back(make_request(ACT_TICK, 0, 2));
      pending_requests.push_back(make_request(ACT_PULSE, 0, 3));
      drain();

      // unit constant, reverse: energy wrap, slot wrap, power overflow, negative power
      set_meter(16'd1, 2'd2);
      pending_requests.push_back(make_request(ACT_PULSE, 65535, 0));
      pending_requests.push_back(make_request(ACT_PULSE, 65535, 255));
      for (int i = 0; i < 5; i++)
         pending_requests.push_back(make_request(ACT_TICK, 65535, 1));
      pending_requests.push_back(make_request(ACT_PULSE, 100, 2));
      pending_requests.push_back(make_request(ACT_TICK, 0, 5));
      pending_requests.push_back(make_request(ACT_PULSE, 0, 1));
      drain();

      // largest constant, forward: remainder carry, tariff mapping
      set_meter(16'hFFFF, 2'd1);
      pending_requests.push_back(make_request(ACT_PULSE, 65535, 4));
      pending_requests.push_back(make_request(ACT_PULSE, 1, 5));
      pending_requests.push_back(make_request(ACT_PULSE, 7, 3));
      pending_requests.push_back(make_request(ACT_PULSE, 0, 0));
      pending_requests.push_back(make_request(ACT_TICK, 12345, 200));
      pending_requests.push_back(make_request(ACT_TICK, 0, 128));
      drain();

      // random traffic over several settings
      for (int s = 0; s < RANDOM_SETS; s++) begin
         case (s)
            0:       k = 16'd1;
            1:       k = 16'hFFFF;
            2:       k = 16'd0;
            3:       k = 16'd7;
            4:       k = 16'd10000;
            default: k = CONST_W'($urandom_range(2, 65534));
         endcase
         set_meter(k, DIR_W'(s));
         for (int i = 0; i < ITEMS_PER_SET; i++)
            pending_requests.push_back(random_request());
         drain();
      end

      if (fail_count == 0) begin
         $display("** pulse_input_energy_power_meter_top: PASSED **");
      end else begin
         $display("** pulse_input_energy_power_meter_top: FAILED **");
      end
      $finish;
   end

endmodule
